// ===== sv/dlaw_pkg.sv =====
// Package for the decimal list average window block.
// Shared constants, parameter defaults and the ring command struct; no dependencies.
package dlaw_pkg;

   localparam int DEF_RING_DEPTH    = 5;
   localparam int DEF_NUMBER_BITS   = 31;
   localparam int DEF_COUNT_BITS    = 16;
   localparam int DEF_FRACTION_BITS = 8;

   localparam int CHAR_BITS = 8;
   localparam int AVG_BITS  = 39;
   localparam int POS_BITS  = 3;

   localparam logic [CHAR_BITS-1:0] CHAR_ZERO = 8'h30;
   localparam logic [CHAR_BITS-1:0] CHAR_NINE = 8'h39;

   localparam logic STATUS_OK    = 1'b0;
   localparam logic STATUS_EMPTY = 1'b1;

   typedef struct packed {
      logic write_avg;
      logic load_entry;
      logic load_error;
      logic last_entry;
   } ring_cmd_type;

endpackage

// ===== sv/dlaw_if.sv =====
// Valid/ready channel interfaces for request bytes and response averages.
// Depends on dlaw_pkg for field widths.
interface dlaw_req_if
   import dlaw_pkg::*;
   ();
   logic                 valid;
   logic                 ready;
   logic [CHAR_BITS-1:0] char_byte;
   logic                 packet_end;

   modport source (output valid, output char_byte, output packet_end, input ready);
   modport sink   (input valid, input char_byte, input packet_end, output ready);
endinterface

interface dlaw_rsp_if
   import dlaw_pkg::*;
   ();
   logic                valid;
   logic                ready;
   logic                status;
   logic [AVG_BITS-1:0] avg_value;
   logic [POS_BITS-1:0] ring_position;
   logic                run_last;

   modport source (output valid, output status, output avg_value, output ring_position,
                   output run_last, input ready);
   modport sink   (input valid, input status, input avg_value, input ring_position,
                   input run_last, output ready);
endinterface

// ===== sv/dlaw_scan.sv =====
// Digit scanner: builds saturating decimal numbers and the packet sum and count.
// Depends on dlaw_pkg for character constants.
module dlaw_scan
   import dlaw_pkg::*;
#(
   parameter int NUMBER_BITS = DEF_NUMBER_BITS,
   parameter int COUNT_BITS  = DEF_COUNT_BITS,
   localparam int SUM_BITS   = NUMBER_BITS + COUNT_BITS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  logic [CHAR_BITS-1:0]  char_byte,
   input  logic                  packet_end,
   output logic [SUM_BITS-1:0]   fin_sum,
   output logic [COUNT_BITS-1:0] fin_count
);

   localparam int PROD_BITS = NUMBER_BITS + 4;

   logic [NUMBER_BITS-1:0] digit_ff, digit_in;
   logic                   in_num_ff, in_num_in;
   logic [SUM_BITS-1:0]    sum_ff, sum_in;
   logic [COUNT_BITS-1:0]  count_ff, count_in;

   logic                   is_digit;
   logic [CHAR_BITS-1:0]   digit_off;
   logic [PROD_BITS-1:0]   prod;
   logic [NUMBER_BITS-1:0] digit_new;
   logic                   close_now;
   logic [NUMBER_BITS-1:0] close_val;

   always_comb begin
      is_digit  = (char_byte >= CHAR_ZERO) && (char_byte <= CHAR_NINE);
      digit_off = char_byte - CHAR_ZERO;
      // times ten as shift and add, then saturate
      prod = (PROD_BITS'(digit_ff) << 3) + (PROD_BITS'(digit_ff) << 1)
             + PROD_BITS'(digit_off[3:0]);
      if (prod > PROD_BITS'({NUMBER_BITS{1'b1}})) begin
         digit_new = {NUMBER_BITS{1'b1}};
      end else begin
         digit_new = prod[NUMBER_BITS-1:0];
      end

      // a non-digit closes the open number; a digit on the last byte closes the new one
      close_now = is_digit ? packet_end : in_num_ff;
      close_val = is_digit ? digit_new : digit_ff;

      fin_sum   = sum_ff;
      fin_count = count_ff;
      if (close_now && (count_ff != {COUNT_BITS{1'b1}})) begin
         fin_sum   = sum_ff + SUM_BITS'(close_val);
         fin_count = count_ff + COUNT_BITS'(1);
      end

      digit_in  = digit_ff;
      in_num_in = in_num_ff;
      sum_in    = sum_ff;
      count_in  = count_ff;
      if (accept) begin
         if (is_digit && !packet_end) begin
            digit_in  = digit_new;
            in_num_in = 1'b1;
         end else begin
            digit_in  = '0;
            in_num_in = 1'b0;
         end
         if (packet_end) begin
            sum_in   = '0;
            count_in = '0;
         end else begin
            sum_in   = fin_sum;
            count_in = fin_count;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         digit_ff  <= '0;
         in_num_ff <= 1'b0;
         sum_ff    <= '0;
         count_ff  <= '0;
      end else begin
         digit_ff  <= digit_in;
         in_num_ff <= in_num_in;
         sum_ff    <= sum_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== sv/dlaw_div.sv =====
// Restoring divider, one quotient bit per cycle, for the packet average.
// Depends on dlaw_pkg for parameter defaults.
module dlaw_div
   import dlaw_pkg::*;
#(
   parameter int DIV_BITS   = DEF_NUMBER_BITS + DEF_COUNT_BITS + DEF_FRACTION_BITS,
   parameter int COUNT_BITS = DEF_COUNT_BITS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DIV_BITS-1:0]   dividend,
   input  logic [COUNT_BITS-1:0] divisor,
   output logic                  done,
   output logic [DIV_BITS-1:0]   quotient
);

   localparam int STEP_BITS = $clog2(DIV_BITS);

   logic [DIV_BITS-1:0]   work_ff, work_in;
   logic [COUNT_BITS-1:0] rem_ff, rem_in;
   logic [COUNT_BITS-1:0] dsr_ff, dsr_in;
   logic [STEP_BITS-1:0]  step_ff, step_in;
   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;

   logic [COUNT_BITS:0]   trial;
   logic [COUNT_BITS:0]   diff;
   logic                  fits;

   always_comb begin
      trial = {rem_ff, work_ff[DIV_BITS-1]};
      diff  = trial - {1'b0, dsr_ff};
      fits  = trial >= {1'b0, dsr_ff};

      work_in = work_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         work_in = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
         step_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // shift in the next dividend bit, subtract when it fits
         rem_in  = fits ? diff[COUNT_BITS-1:0] : trial[COUNT_BITS-1:0];
         work_in = {work_ff[DIV_BITS-2:0], fits};
         step_in = step_ff + STEP_BITS'(1);
         if (step_ff == STEP_BITS'(DIV_BITS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      work_ff <= work_in;
      rem_ff  <= rem_in;
      dsr_ff  <= dsr_in;
   end

   assign done     = done_ff;
   assign quotient = work_ff;

endmodule

// ===== sv/dlaw_ring.sv =====
// Ring of recent averages with its response register.
// Depends on dlaw_pkg for field widths and the ring command struct.
module dlaw_ring
   import dlaw_pkg::*;
#(
   parameter int RING_DEPTH = DEF_RING_DEPTH,
   localparam int FILL_BITS = $clog2(RING_DEPTH + 1),
   localparam int SLOT_BITS = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1
) (
   input  logic                 clock,
   input  logic                 reset,
   input  ring_cmd_type         cmd,
   input  logic [AVG_BITS-1:0]  write_data,
   input  logic [FILL_BITS-1:0] read_idx,
   output logic [FILL_BITS-1:0] fill,
   output logic                 out_free,
   dlaw_rsp_if.source           rsp_ch
);

   localparam int WRAP_BITS = FILL_BITS + 1;
   localparam int POS_EXT   = (FILL_BITS > POS_BITS) ? FILL_BITS : POS_BITS;

   logic [AVG_BITS-1:0] ring_mem [RING_DEPTH];

   logic [SLOT_BITS-1:0] oldest_ff, oldest_in;
   logic [FILL_BITS-1:0] fill_ff, fill_in;
   logic                 valid_ff, valid_in;
   logic                 status_ff;
   logic [AVG_BITS-1:0]  avg_ff;
   logic [POS_BITS-1:0]  pos_ff;
   logic                 last_ff;

   logic [WRAP_BITS-1:0] wr_raw, rd_raw, adv_raw;
   logic [SLOT_BITS-1:0] wr_slot, rd_slot, adv_slot;
   logic                 full;
   logic [POS_EXT-1:0]   pos_ext;

   function automatic logic [SLOT_BITS-1:0] wrap(input logic [WRAP_BITS-1:0] raw);
      logic [WRAP_BITS-1:0] fixed;
      begin
         fixed = (raw >= WRAP_BITS'(RING_DEPTH)) ? raw - WRAP_BITS'(RING_DEPTH) : raw;
         wrap  = fixed[SLOT_BITS-1:0];
      end
   endfunction

   always_comb begin
      full     = fill_ff == FILL_BITS'(RING_DEPTH);
      wr_raw   = WRAP_BITS'(oldest_ff) + WRAP_BITS'(fill_ff);
      rd_raw   = WRAP_BITS'(oldest_ff) + WRAP_BITS'(read_idx);
      adv_raw  = WRAP_BITS'(oldest_ff) + WRAP_BITS'(1);
      wr_slot  = full ? oldest_ff : wrap(wr_raw);
      rd_slot  = wrap(rd_raw);
      adv_slot = wrap(adv_raw);
      pos_ext  = POS_EXT'(read_idx);

      oldest_in = oldest_ff;
      fill_in   = fill_ff;
      if (cmd.write_avg) begin
         // overwrite the oldest once full
         if (full) begin
            oldest_in = adv_slot;
         end else begin
            fill_in = fill_ff + FILL_BITS'(1);
         end
      end

      out_free = !valid_ff || rsp_ch.ready;
      valid_in = valid_ff && !rsp_ch.ready;
      if (cmd.load_entry || cmd.load_error) begin
         valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.write_avg) begin
         ring_mem[wr_slot] <= write_data;
      end
      if (cmd.load_entry) begin
         avg_ff    <= ring_mem[rd_slot];
         status_ff <= STATUS_OK;
         pos_ff    <= pos_ext[POS_BITS-1:0];
         last_ff   <= cmd.last_entry;
      end else if (cmd.load_error) begin
         avg_ff    <= '0;
         status_ff <= STATUS_EMPTY;
         pos_ff    <= '0;
         last_ff   <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         oldest_ff <= '0;
         fill_ff   <= '0;
         valid_ff  <= 1'b0;
      end else begin
         oldest_ff <= oldest_in;
         fill_ff   <= fill_in;
         valid_ff  <= valid_in;
      end
   end

   assign fill                 = fill_ff;
   assign rsp_ch.valid         = valid_ff;
   assign rsp_ch.status        = status_ff;
   assign rsp_ch.avg_value     = avg_ff;
   assign rsp_ch.ring_position = pos_ff;
   assign rsp_ch.run_last      = last_ff;

endmodule

// ===== sv/decimal_list_average_window.sv =====
// Decimal list average window. A byte that does not end a packet leaves the block
// idle. The last byte of a packet holds off further requests while a bit-serial
// divider forms sum * 2^FRACTION_BITS / count, one quotient bit a cycle, over
// NUMBER_BITS + COUNT_BITS + FRACTION_BITS quotient bits. The ring then stores the
// new average and sends every stored average, oldest first, one per cycle the
// response side takes. A packet with no numbers gives a single response with
// status 1 and leaves the ring as it was.
module decimal_list_average_window
   import dlaw_pkg::*;
#(
   parameter int RING_DEPTH    = DEF_RING_DEPTH,
   parameter int NUMBER_BITS   = DEF_NUMBER_BITS,
   parameter int COUNT_BITS    = DEF_COUNT_BITS,
   parameter int FRACTION_BITS = DEF_FRACTION_BITS
) (
   input  logic        clock,
   input  logic        reset,
   dlaw_req_if.sink    req_ch,
   dlaw_rsp_if.source  rsp_ch
);

   localparam int SUM_BITS  = NUMBER_BITS + COUNT_BITS;
   localparam int DIV_BITS  = SUM_BITS + FRACTION_BITS;
   localparam int QEXT_BITS = (DIV_BITS > AVG_BITS) ? DIV_BITS : AVG_BITS;
   localparam int FILL_BITS = $clog2(RING_DEPTH + 1);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_DIVIDE = 3'd1;
   localparam logic [2:0] ST_EMIT   = 3'd2;
   localparam logic [2:0] ST_ERROR  = 3'd3;

   logic [2:0]           state_ff, state_in;
   logic [FILL_BITS-1:0] idx_ff, idx_in;

   logic                  accept;
   logic [SUM_BITS-1:0]   fin_sum;
   logic [COUNT_BITS-1:0] fin_count;
   logic                  div_start;
   logic                  div_done;
   logic [DIV_BITS-1:0]   div_dividend;
   logic [DIV_BITS-1:0]   div_quot;
   logic [QEXT_BITS-1:0]  quot_ext;
   logic [FILL_BITS-1:0]  fill;
   logic                  out_free;
   logic                  is_last;
   ring_cmd_type          cmd;

   assign req_ch.ready = (state_ff == ST_IDLE) && !reset;
   assign accept       = req_ch.valid && req_ch.ready;
   assign div_start    = accept && req_ch.packet_end && (fin_count != '0);
   assign div_dividend = DIV_BITS'(fin_sum) << FRACTION_BITS;
   assign quot_ext     = QEXT_BITS'(div_quot);

   dlaw_scan #(
      .NUMBER_BITS (NUMBER_BITS),
      .COUNT_BITS  (COUNT_BITS)
   ) u_scan (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .char_byte  (req_ch.char_byte),
      .packet_end (req_ch.packet_end),
      .fin_sum    (fin_sum),
      .fin_count  (fin_count)
   );

   dlaw_div #(
      .DIV_BITS   (DIV_BITS),
      .COUNT_BITS (COUNT_BITS)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (fin_count),
      .done     (div_done),
      .quotient (div_quot)
   );

   dlaw_ring #(
      .RING_DEPTH (RING_DEPTH)
   ) u_ring (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .write_data (quot_ext[AVG_BITS-1:0]),
      .read_idx   (idx_ff),
      .fill       (fill),
      .out_free   (out_free),
      .rsp_ch     (rsp_ch)
   );

   always_comb begin
      state_in       = state_ff;
      idx_in         = idx_ff;
      is_last        = idx_ff == (fill - FILL_BITS'(1));
      cmd.write_avg  = 1'b0;
      cmd.load_entry = 1'b0;
      cmd.load_error = 1'b0;
      cmd.last_entry = is_last;
      case (state_ff)
         ST_IDLE: begin
            if (accept && req_ch.packet_end) begin
               state_in = (fin_count != '0) ? ST_DIVIDE : ST_ERROR;
            end
         end
         ST_DIVIDE: begin
            if (div_done) begin
               cmd.write_avg = 1'b1;
               idx_in        = '0;
               state_in      = ST_EMIT;
            end
         end
         ST_EMIT: begin
            // advance one stored average each time the response register frees
            if (out_free) begin
               cmd.load_entry = 1'b1;
               idx_in         = idx_ff + FILL_BITS'(1);
               if (is_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_ERROR: begin
            if (out_free) begin
               cmd.load_error = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
      end
   end

`ifndef SYNTHESIS
   a_done_in_divide: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == ST_DIVIDE)
      else $error("divider finished outside the divide state");

   a_emit_has_entries: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EMIT |-> (fill != '0) && (idx_ff < fill))
      else $error("ring read beyond its filled entries");

   a_last_blocks: assert property (@(posedge clock) disable iff (reset)
      (accept && req_ch.packet_end) |=> !req_ch.ready)
      else $error("request taken while a packet result is pending");

   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      div_start |=> state_ff == ST_DIVIDE)
      else $error("divider started without entering the divide state");
`endif

endmodule

// ===== tb/decimal_list_average_window_tb.sv =====
// Testbench for decimal_list_average_window: drives packets of text bytes and
// checks every emitted average of the ring against an in-bench prediction.
// Depends on dlaw_pkg, the dlaw_req_if/dlaw_rsp_if interfaces and the block itself.
module decimal_list_average_window_tb;
   import dlaw_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam longint unsigned NUM_MAX   = (64'd1 << DEF_NUMBER_BITS) - 1;
   localparam longint unsigned COUNT_MAX = (64'd1 << DEF_COUNT_BITS) - 1;
   localparam longint unsigned AVG_MASK  = (64'd1 << AVG_BITS) - 1;
   localparam int QUIET_LIMIT  = 3000;
   localparam int HOLD_AT      = 60;
   localparam int HOLD_CYCLES  = 400;
   localparam int DRAIN_CYCLES = 100;
   localparam int RANDOM_BYTES = 345;

   typedef struct packed {
      logic [CHAR_BITS-1:0] char_byte;
      logic                 packet_end;
   } text_byte_type;

   typedef struct packed {
      logic                status;
      logic [AVG_BITS-1:0] avg_value;
      logic [POS_BITS-1:0] ring_position;
      logic                run_last;
   } avg_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   dlaw_req_if req ();
   dlaw_rsp_if rsp ();

   decimal_list_average_window dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req),
      .rsp_ch (rsp)
   );

   always #6 clock = ~clock;

   text_byte_type  text_queue[$];
   avg_result_type avg_expected[$];

   // predicted state of the block
   longint unsigned digit_acc  = 0;
   bit              digit_open = 0;
   longint unsigned sum_acc    = 0;
   longint unsigned num_count  = 0;
   longint unsigned avg_window[DEF_RING_DEPTH];
   int              win_oldest = 0;
   int              win_fill   = 0;

   int  fail_count  = 0;
   int  taken       = 0;
   int  rsp_seen    = 0;
   int  quiet       = 0;
   int  sent        = 0;
   int  total_items = 0;
   int  calm_lo     = 0;
   bit  req_fire    = 0;
   int  hold_left   = 0;
   bit  held        = 0;

   task automatic close_number();
      if (digit_open && num_count < COUNT_MAX) begin
         sum_acc   += digit_acc;
         num_count += 1;
      end
      digit_open = 0;
      digit_acc  = 0;
   endtask

   task automatic predict_byte(input logic [CHAR_BITS-1:0] b, input logic last);
      longint unsigned grown;
      longint unsigned avg;
      avg_result_type  r;
      if (b >= CHAR_ZERO && b <= CHAR_NINE) begin
         grown      = digit_acc * 10 + (b - CHAR_ZERO);
         digit_acc  = (grown > NUM_MAX) ? NUM_MAX : grown;
         digit_open = 1;
      end else begin
         close_number();
      end
      if (last) begin
         close_number();
         if (num_count == 0) begin
            r.status        = STATUS_EMPTY;
            r.avg_value     = '0;
            r.ring_position = '0;
            r.run_last      = 1'b1;
            avg_expected.push_back(r);
         end else begin
            avg = ((sum_acc << DEF_FRACTION_BITS) / num_count) & AVG_MASK;
            if (win_fill < DEF_RING_DEPTH) begin
               avg_window[(win_oldest + win_fill) % DEF_RING_DEPTH] = avg;
               win_fill++;
            end else begin
               avg_window[win_oldest] = avg;
               win_oldest = (win_oldest + 1) % DEF_RING_DEPTH;
            end
            for (int i = 0; i < win_fill; i++) begin
               r.status        = STATUS_OK;
               r.avg_value     = AVG_BITS'(avg_window[(win_oldest + i) % DEF_RING_DEPTH]);
               r.ring_position = POS_BITS'(i);
               r.run_last      = (i == win_fill - 1);
               avg_expected.push_back(r);
            end
         end
         sum_acc   = 0;
         num_count = 0;
      end
   endtask

   task automatic check_response();
      avg_result_type want;
      if (avg_expected.size() == 0) begin
         $error("response with no average pending: avg_value %0d", rsp.avg_value);
         fail_count++;
      end else begin
         want = avg_expected.pop_front();
         if (rsp.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, rsp.status);
            fail_count++;
         end
         if (rsp.avg_value !== want.avg_value) begin
            $error("avg_value: expected %0d, actual %0d", want.avg_value, rsp.avg_value);
            fail_count++;
         end
         if (rsp.ring_position !== want.ring_position) begin
            $error("ring_position: expected %0d, actual %0d",
                   want.ring_position, rsp.ring_position);
            fail_count++;
         end
         if (rsp.run_last !== want.run_last) begin
            $error("run_last: expected %0d, actual %0d", want.run_last, rsp.run_last);
            fail_count++;
         end
      end
   endtask

   // request before response, so a same-edge answer finds its expectation
   always @(posedge clock) begin
      if (reset) begin
         req_fire <= 0;
         quiet    <= 0;
      end else begin
         req_fire <= req.valid && req.ready;
         if (req.valid && req.ready) begin
            predict_byte(req.char_byte, req.packet_end);
            taken <= taken + 1;
         end
         if (rsp.valid && rsp.ready) begin
            check_response();
            rsp_seen <= rsp_seen + 1;
         end
         if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
            quiet <= 0;
         end else if (quiet >= QUIET_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
         end else begin
            quiet <= quiet + 1;
         end
      end
   end

   always @(negedge clock) begin
      text_byte_type nxt;
      if (reset) begin
         req.valid <= 1'b0;
      end else if (!req.valid || req_fire) begin
         if (text_queue.size() > 0 &&
             ((sent >= calm_lo && sent < calm_lo + 120) || $urandom_range(99) >= 33)) begin
            nxt = text_queue.pop_front();
            req.valid      <= 1'b1;
            req.char_byte  <= nxt.char_byte;
            req.packet_end <= nxt.packet_end;
            sent           <= sent + 1;
         end else begin
            req.valid <= 1'b0;
         end
      end
   end

   // one long hold-off lets the block fill up and stall its input
   always @(negedge clock) begin
      if (reset) begin
         rsp.ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp.ready <= 1'b0;
      end else if (!held && rsp_seen >= HOLD_AT) begin
         held      <= 1;
         hold_left <= HOLD_CYCLES;
         rsp.ready <= 1'b0;
      end else if (rsp_seen >= 90 && rsp_seen < 130) begin
         rsp.ready <= 1'b1;
      end else begin
         rsp.ready <= ($urandom_range(99) >= 33);
      end
   end

   task automatic put_byte(input logic [CHAR_BITS-1:0] b, input logic last);
      text_byte_type e;
      e.char_byte  = b;
      e.packet_end = last;
      text_queue.push_back(e);
   endtask

   task automatic put_text(input string s, input logic last);
      for (int i = 0; i < s.len(); i++) begin
         put_byte(s[i], last && (i == s.len() - 1));
      end
   endtask

   function automatic logic [CHAR_BITS-1:0] non_digit();
      logic [CHAR_BITS-1:0] b;
      do begin
         b = CHAR_BITS'($urandom_range(255));
      end while (b >= CHAR_ZERO && b <= CHAR_NINE);
      return b;
   endfunction

   task automatic put_random_packet();
      text_byte_type pkt[$];
      text_byte_type e;
      int kind;
      int nums;
      int digits;
      kind = $urandom_range(99);
      e.packet_end = 1'b0;
      if (kind < 78) begin
         nums = $urandom_range(1, 6);
         if ($urandom_range(3) == 0) begin
            e.char_byte = non_digit();
            pkt.push_back(e);
         end
         for (int n = 0; n < nums; n++) begin
            digits = ($urandom_range(9) == 0) ? $urandom_range(9, 13) : $urandom_range(1, 4);
            for (int d = 0; d < digits; d++) begin
               e.char_byte = CHAR_BITS'(CHAR_ZERO + $urandom_range(9));
               pkt.push_back(e);
            end
            if (n < nums - 1 || $urandom_range(2) == 0) begin
               for (int k = $urandom_range(1, 2); k > 0; k--) begin
                  e.char_byte = non_digit();
                  pkt.push_back(e);
               end
            end
         end
      end else if (kind < 90) begin
         for (int k = $urandom_range(1, 3); k > 0; k--) begin
            e.char_byte = non_digit();
            pkt.push_back(e);
         end
      end else begin
         for (int k = $urandom_range(1, 8); k > 0; k--) begin
            e.char_byte = CHAR_BITS'($urandom_range(255));
            pkt.push_back(e);
         end
      end
      pkt[pkt.size() - 1].packet_end = 1'b1;
      foreach (pkt[i]) text_queue.push_back(pkt[i]);
   endtask

   initial begin
      int base;
      req.valid      = 1'b0;
      req.char_byte  = '0;
      req.packet_end = 1'b0;
      rsp.ready      = 1'b0;

      // empty packet made of a zero byte, before any average is stored
      put_byte(8'h00, 1'b1);
      // lone zero, digit as the last byte
      put_text("0", 1'b1);
      // saturating digit run closed by an all-ones byte
      put_text("9999999999", 1'b0);
      put_byte(8'hFF, 1'b1);
      // bytes just outside the digit range and a zero byte split numbers only
      put_text("7/", 1'b0);
      put_byte(8'h00, 1'b0);
      put_text(":2", 1'b1);
      // empty packet with averages already stored
      put_text(" ", 1'b1);
      put_text("5", 1'b1);
      put_text("1", 1'b0);
      put_byte(8'h80, 1'b0);
      put_text("2", 1'b1);
      // sixth average wraps the ring
      put_text("3", 1'b1);

      base    = text_queue.size();
      calm_lo = base + 150;
      while (text_queue.size() < base + RANDOM_BYTES) put_random_packet();
      total_items = text_queue.size();

      repeat (2) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      while (taken != total_items) @(posedge clock);
      while (avg_expected.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fail_count == 0 && avg_expected.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
